// ----- rtl/cbim_pkg.sv -----
// ----------------------------------------------------------------------------
// cbim_pkg: shared types and constants for the cartridge bank IRQ mapper
// Holds the operation and target codes and the field widths of both streams.
// ----------------------------------------------------------------------------
package cbim_pkg;

	// Operation carried with each input transfer.
	typedef enum logic [1:0] {
		OP_CPU_WRITE = 2'd0,
		OP_CPU_READ  = 2'd1,
		OP_PPU_READ  = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	// Destination of a translated access.
	typedef enum logic [2:0] {
		TGT_NONE  = 3'd0,
		TGT_PRG   = 3'd1,
		TGT_WRAM  = 3'd2,
		TGT_CHR   = 3'd3,
		TGT_NT    = 3'd4,
		TGT_SOUND = 3'd5
	} target_t;

	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int MAP_ADDR_W = 21;
	localparam int COUNTER_W  = 15;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;

	// Fixed bank that answers the top program window.
	localparam logic [BYTE_W-1:0] PRG_FIXED_BANK = 8'hFF;

endpackage

// ----- rtl/cartridge_bank_irq_mapper.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_irq_mapper: bank-switching mapper with a cycle-counting IRQ
// Decodes CPU writes into pattern, program and nametable bank registers and a
// 15-bit interrupt counter, and translates CPU and PPU lookups into physical
// offsets in program ROM, work RAM, pattern ROM, nametable RAM or sound chip.
//
// An input transfer is held in the input register, its result in the output
// register. Throughput: 1 item per cycle while the master side takes results;
// the bank decode and the counter add sit in one stage between these registers.
// Reset: arst_n clears both pipeline valids, the IRQ state and loads the
// power-on bank values.
// ----------------------------------------------------------------------------
module cartridge_bank_irq_mapper #(
	parameter int PATTERN_BANK_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tdata fields from bit 0 up: address[15:0], data[7:0], cycles[7:0].
	input  logic [cbim_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser fields from bit 0 up: opcode[1:0].
	input  logic [1:0]                    s_tuser,
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata fields from bit 0 up: mapped_address[20:0], out_data[7:0], irq,
	// two zero pad bits.
	output logic [cbim_pkg::OUT_DATA_W-1:0] m_tdata,
	// tuser fields from bit 0 up: target[2:0].
	output logic [2:0]                    m_tuser
);

	import cbim_pkg::*;

	localparam int PB_IDX_W = $clog2(PATTERN_BANK_COUNT);

	// Input register.
	logic                valid_s1;
	op_t                 op_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [BYTE_W-1:0]   data_s1;
	logic [BYTE_W-1:0]   cycles_s1;

	// Output register.
	logic                  valid_s2;
	target_t               target_s2;
	logic [MAP_ADDR_W-1:0] map_addr_s2;
	logic [BYTE_W-1:0]     out_data_s2;
	logic                  irq_s2;

	// Mapper state.
	logic [BYTE_W-1:0]    pattern_q [PATTERN_BANK_COUNT];
	logic [BYTE_W-1:0]    program_q [3];
	logic [BYTE_W-1:0]    nametable_q [4];
	logic                 irq_enable_q;
	logic [COUNTER_W-1:0] irq_counter_q;
	logic                 irq_line_q;

	logic advance;
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Decode and state update for the item held in the input register.
	target_t               tgt;
	logic [MAP_ADDR_W-1:0] map_addr;
	logic [BYTE_W-1:0]     out_data;
	logic                  pat_we;
	logic                  prg_we;
	logic                  nt_we;
	logic                  cnt_lo_we;
	logic                  cnt_hi_we;
	logic                  tick_fire;
	logic                  tick_add;
	logic                  irq_next;
	logic [COUNTER_W:0]    sum;
	logic [BYTE_W-1:0]     prg_bank;
	logic [BYTE_W-1:0]     ppu_bank;
	logic [ADDR_W-1:0]     ppu_addr;
	logic                  in_sound;
	logic                  in_wram;

	always_comb begin
		tgt       = TGT_NONE;
		map_addr  = '0;
		out_data  = '0;
		pat_we    = 1'b0;
		prg_we    = 1'b0;
		nt_we     = 1'b0;
		cnt_lo_we = 1'b0;
		cnt_hi_we = 1'b0;
		tick_fire = 1'b0;
		tick_add  = 1'b0;
		sum       = {1'b0, irq_counter_q} + (COUNTER_W+1)'(cycles_s1);
		in_sound  = (addr_s1[15:11] == 5'b01001);
		in_wram   = (addr_s1[15:13] == 3'b011);
		ppu_addr  = {2'b00, addr_s1[13:0]};

		case (addr_s1[14:13])
			2'd0:    prg_bank = program_q[0];
			2'd1:    prg_bank = program_q[1];
			2'd2:    prg_bank = program_q[2];
			default: prg_bank = PRG_FIXED_BANK;
		endcase

		if (!ppu_addr[13]) begin
			ppu_bank = pattern_q[ppu_addr[10 +: PB_IDX_W]];
		end else begin
			ppu_bank = nametable_q[ppu_addr[11:10]];
		end

		case (op_s1)
			OP_CPU_WRITE: begin
				if (in_sound) begin
					tgt      = TGT_SOUND;
					map_addr = MAP_ADDR_W'(addr_s1);
					out_data = data_s1;
				end else if (in_wram) begin
					tgt      = TGT_WRAM;
					map_addr = MAP_ADDR_W'(addr_s1[12:0]);
					out_data = data_s1;
				end else if (addr_s1[15:14] == 2'b10) begin
					if (addr_s1[10]) begin
						cnt_hi_we = addr_s1[13];
						cnt_lo_we = !addr_s1[13];
					end else begin
						pat_we = 1'b1;
					end
				end else if (addr_s1[15:13] == 3'b110) begin
					nt_we = !addr_s1[10];
				end else if (addr_s1[15:13] == 3'b111) begin
					// Upper half with bit 11 set is the sound chip port.
					if (addr_s1[12] && addr_s1[11]) begin
						tgt      = TGT_SOUND;
						map_addr = MAP_ADDR_W'(addr_s1);
						out_data = data_s1;
					end else begin
						prg_we = !addr_s1[10];
					end
				end
			end
			OP_CPU_READ: begin
				if (in_sound) begin
					tgt      = TGT_SOUND;
					map_addr = MAP_ADDR_W'(addr_s1);
				end else if (in_wram) begin
					tgt      = TGT_WRAM;
					map_addr = MAP_ADDR_W'(addr_s1[12:0]);
				end else if (addr_s1[15]) begin
					tgt      = TGT_PRG;
					map_addr = {prg_bank, addr_s1[12:0]};
				end
			end
			OP_PPU_READ: begin
				tgt      = ppu_addr[13] ? TGT_NT : TGT_CHR;
				map_addr = MAP_ADDR_W'({ppu_bank, ppu_addr[9:0]});
			end
			default: begin
				// Cycle tick: count only while enabled.
				if (irq_enable_q) begin
					tick_fire = sum[COUNTER_W];
					tick_add  = !sum[COUNTER_W];
				end
			end
		endcase

		if (cnt_hi_we) begin
			irq_next = 1'b0;
		end else if (tick_fire) begin
			irq_next = 1'b1;
		end else begin
			irq_next = irq_line_q;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1     <= op_t'(s_tuser);
			addr_s1   <= s_tdata[15:0];
			data_s1   <= s_tdata[23:16];
			cycles_s1 <= s_tdata[31:24];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2   <= tgt;
			map_addr_s2 <= map_addr;
			out_data_s2 <= out_data;
			irq_s2      <= irq_next;
		end
	end

	// Bank registers and interrupt state, updated as an item leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_BANK_COUNT; i++) begin
				pattern_q[i] <= BYTE_W'(i);
			end
			program_q[0]   <= 8'd0;
			program_q[1]   <= 8'd1;
			program_q[2]   <= 8'd2;
			nametable_q[0] <= 8'd0;
			nametable_q[1] <= 8'd0;
			nametable_q[2] <= 8'd1;
			nametable_q[3] <= 8'd1;
			irq_enable_q   <= 1'b0;
			irq_counter_q  <= '0;
			irq_line_q     <= 1'b0;
		end else if (advance) begin
			if (pat_we) begin
				pattern_q[addr_s1[11 +: PB_IDX_W]] <= data_s1;
			end
			if (prg_we) begin
				// The fixed bank's slot never decodes as a write here.
				case (addr_s1[12:11])
					2'd0:    program_q[0] <= data_s1;
					2'd1:    program_q[1] <= data_s1;
					default: program_q[2] <= data_s1;
				endcase
			end
			if (nt_we) begin
				nametable_q[addr_s1[12:11]] <= data_s1;
			end
			if (cnt_lo_we) begin
				irq_counter_q[7:0] <= data_s1;
			end
			if (cnt_hi_we) begin
				irq_counter_q[14:8] <= data_s1[6:0];
				irq_enable_q        <= data_s1[7];
			end
			if (tick_fire) begin
				irq_counter_q <= '0;
				irq_enable_q  <= 1'b0;
			end else if (tick_add) begin
				irq_counter_q <= sum[COUNTER_W-1:0];
			end
			irq_line_q <= irq_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = target_s2;
	assign m_tdata  = {2'b00, irq_s2, out_data_s2, map_addr_s2};

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cartridge bank IRQ mapper
// Drives CPU writes, CPU and PPU lookups and cycle ticks into the input stream.
// Each accepted transfer runs through a local mapper model, and every result
// transfer is compared field by field with the oldest expected answer.
// A short scripted sequence covers reset values, window edges, the interrupt
// and its acknowledge. Random traffic follows, with register and counter
// sequences that drive the interrupt often. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import cbim_pkg::*;

	localparam int CHR_BANKS     = 8;
	localparam int RESET_CYCLES  = 9;
	localparam int PAUSE_AT      = 900;
	localparam int HOLD_AT       = 600;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_AT      = 1450;
	localparam int TOTAL_ITEMS   = 1830;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int N_SCRIPT      = 29;

	// One answer of the mapper, as carried on the result stream.
	typedef struct packed {
		target_t                tgt;
		logic [MAP_ADDR_W-1:0] maddr;
		logic [BYTE_W-1:0]     wdata;
		logic                  irq;
	} bus_answer_t;

	// One scripted access; the answer is used only where given is set.
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
		logic [BYTE_W-1:0] cyc;
		logic              given;
		bus_answer_t       answer;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = OP_CPU_WRITE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;

	// Local copy of the mapper state.
	logic [BYTE_W-1:0] prg_bank [4];
	logic [BYTE_W-1:0] chr_bank [CHR_BANKS];
	logic [BYTE_W-1:0] nt_page [4];
	logic              irq_en;
	logic [15:0]       irq_cnt;
	logic              irq_level;

	bus_answer_t answer_q [$];
	int          mismatch_count = 0;
	int          items_issued = 0;
	int          cycle_count = 0;
	int          tx_idle_rate = 20;
	int          rx_idle_rate = 20;
	bit          quiet = 1'b0;
	bit          rx_holding = 1'b0;
	bit          hold_done = 1'b0;

	script_row_t script [N_SCRIPT] = '{
		// Lookups and forwarded writes straight after reset.
		'{OP_CPU_READ,  16'h8000, 8'h00, 8'h00, 1'b1, '{TGT_PRG,   21'h000000, 8'h00, 1'b0}},
		'{OP_CPU_READ,  16'hFFFF, 8'h00, 8'h00, 1'b1, '{TGT_PRG,   21'h1FFFFF, 8'h00, 1'b0}},
		'{OP_PPU_READ,  16'h0000, 8'h00, 8'h00, 1'b1, '{TGT_CHR,   21'h000000, 8'h00, 1'b0}},
		'{OP_PPU_READ,  16'h1FFF, 8'h00, 8'h00, 1'b1, '{TGT_CHR,   21'h001FFF, 8'h00, 1'b0}},
		'{OP_PPU_READ,  16'h3FFF, 8'h00, 8'h00, 1'b1, '{TGT_NT,    21'h0007FF, 8'h00, 1'b0}},
		'{OP_CPU_WRITE, 16'h4800, 8'hFF, 8'h00, 1'b1, '{TGT_SOUND, 21'h004800, 8'hFF, 1'b0}},
		'{OP_CPU_WRITE, 16'h7FFF, 8'hA5, 8'h00, 1'b1, '{TGT_WRAM,  21'h001FFF, 8'hA5, 1'b0}},
		'{OP_CPU_READ,  16'h0000, 8'h00, 8'h00, 1'b1, '{TGT_NONE,  21'h000000, 8'h00, 1'b0}},
		'{OP_TICK,      16'h0000, 8'h00, 8'hFF, 1'b0, '0},
		// Pattern bank write, then a PPU lookup above the 16 KB mirror.
		'{OP_CPU_WRITE, 16'h8000, 8'hFF, 8'h00, 1'b0, '0},
		'{OP_PPU_READ,  16'hC3FF, 8'h00, 8'h00, 1'b0, '0},
		// Counter loaded just below the limit, then ticked across it.
		'{OP_CPU_WRITE, 16'h8400, 8'hF0, 8'h00, 1'b0, '0},
		'{OP_CPU_WRITE, 16'hA400, 8'hFF, 8'h00, 1'b0, '0},
		'{OP_TICK,      16'h0000, 8'h00, 8'h0F, 1'b0, '0},
		'{OP_TICK,      16'h0000, 8'h00, 8'h01, 1'b0, '0},
		'{OP_TICK,      16'h0000, 8'h00, 8'hFF, 1'b0, '0},
		// Acknowledge with the enable bit clear.
		'{OP_CPU_WRITE, 16'hBC00, 8'h00, 8'h00, 1'b0, '0},
		// Nametable page with a full eight-bit value.
		'{OP_CPU_WRITE, 16'hD800, 8'hFF, 8'h00, 1'b0, '0},
		'{OP_PPU_READ,  16'h2C00, 8'h00, 8'h00, 1'b0, '0},
		'{OP_CPU_WRITE, 16'hC400, 8'h55, 8'h00, 1'b0, '0},
		// Program banks and the upper sound-chip window.
		'{OP_CPU_WRITE, 16'hE000, 8'hFF, 8'h00, 1'b0, '0},
		'{OP_CPU_READ,  16'h9FFF, 8'h00, 8'h00, 1'b0, '0},
		'{OP_CPU_WRITE, 16'hF800, 8'h3C, 8'h00, 1'b1, '{TGT_SOUND, 21'h00F800, 8'h3C, 1'b0}},
		'{OP_CPU_WRITE, 16'hF000, 8'h80, 8'h00, 1'b0, '0},
		'{OP_CPU_READ,  16'hC000, 8'h00, 8'h00, 1'b0, '0},
		'{OP_CPU_WRITE, 16'hEC00, 8'h12, 8'h00, 1'b0, '0},
		'{OP_CPU_READ,  16'h4FFF, 8'h00, 8'h00, 1'b1, '{TGT_SOUND, 21'h004FFF, 8'h00, 1'b0}},
		'{OP_CPU_READ,  16'h5FFF, 8'h00, 8'h00, 1'b1, '{TGT_NONE,  21'h000000, 8'h00, 1'b0}},
		'{OP_CPU_WRITE, 16'hFFFF, 8'h00, 8'h00, 1'b1, '{TGT_SOUND, 21'h00FFFF, 8'h00, 1'b0}}
	};

	cartridge_bank_irq_mapper #(
		.PATTERN_BANK_COUNT(CHR_BANKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	// Power-on contents of the local mapper state.
	task automatic reset_model();
		prg_bank = '{8'd0, 8'd1, 8'd2, 8'd255};
		for (int i = 0; i < CHR_BANKS; i++) begin
			chr_bank[i] = 8'(i);
		end
		nt_page = '{8'd0, 8'd0, 8'd1, 8'd1};
		irq_en = 1'b0;
		irq_cnt = '0;
		irq_level = 1'b0;
	endtask

	// Applies one access to the local state and returns the mapper's answer.
	function automatic bus_answer_t map_access(input op_t op, input logic [15:0] a,
			input logic [7:0] v, input logic [7:0] cyc);
		bus_answer_t ans;
		logic [16:0] sum;
		ans = '{TGT_NONE, '0, '0, 1'b0};
		case (op)
			OP_CPU_WRITE: begin
				if (a >= 16'h4800 && a <= 16'h4FFF) begin
					ans.tgt = TGT_SOUND;
					ans.maddr = 21'(a);
					ans.wdata = v;
				end else if (a >= 16'h6000 && a <= 16'h7FFF) begin
					ans.tgt = TGT_WRAM;
					ans.maddr = 21'(a[12:0]);
					ans.wdata = v;
				end else if (a >= 16'h8000 && a <= 16'hBFFF) begin
					// Bit 10 selects the counter, bit 13 its high byte.
					if (a[10]) begin
						if (a[13]) begin
							irq_cnt = {1'b0, v[6:0], irq_cnt[7:0]};
							irq_en = v[7];
							irq_level = 1'b0;
						end else begin
							irq_cnt[7:0] = v;
						end
					end else begin
						chr_bank[a[13:11]] = v;
					end
				end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
					if (!a[10]) begin
						nt_page[a[12:11]] = v;
					end
				end else if (a >= 16'hE000) begin
					if (a >= 16'hF000 && a[11]) begin
						ans.tgt = TGT_SOUND;
						ans.maddr = 21'(a);
						ans.wdata = v;
					end else if (!a[10]) begin
						prg_bank[a[12:11]] = v;
					end
				end
			end
			OP_CPU_READ: begin
				if (a >= 16'h4800 && a <= 16'h4FFF) begin
					ans.tgt = TGT_SOUND;
					ans.maddr = 21'(a);
				end else if (a >= 16'h6000 && a <= 16'h7FFF) begin
					ans.tgt = TGT_WRAM;
					ans.maddr = 21'(a[12:0]);
				end else if (a[15]) begin
					ans.tgt = TGT_PRG;
					ans.maddr = {prg_bank[a[14:13]], a[12:0]};
				end
			end
			OP_PPU_READ: begin
				// The PPU space mirrors every 16 KB.
				if (!a[13]) begin
					ans.tgt = TGT_CHR;
					ans.maddr = 21'({chr_bank[a[12:10]], a[9:0]});
				end else begin
					ans.tgt = TGT_NT;
					ans.maddr = 21'({nt_page[a[11:10]], a[9:0]});
				end
			end
			OP_TICK: begin
				if (irq_en) begin
					sum = 17'(irq_cnt) + 17'(cyc);
					if (sum > 17'h07FFF) begin
						irq_level = 1'b1;
						irq_en = 1'b0;
						irq_cnt = '0;
					end else begin
						irq_cnt = sum[15:0];
					end
				end
			end
		endcase
		ans.irq = irq_level;
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
			cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Offers one transfer, waits for the handshake and books its answer.
	task automatic send_item(input op_t op, input logic [15:0] addr, input logic [7:0] wdata,
			input logic [7:0] cyc, input logic given, input bus_answer_t given_answer);
		bus_answer_t ans;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {cyc, wdata, addr};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		ans = map_access(op, addr, wdata, cyc);
		answer_q.push_back(given ? given_answer : ans);
		items_issued++;
		if (!quiet && !rx_holding && $urandom_range(0, 99) < tx_idle_rate) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stops offering until every booked answer has come back.
	task automatic drain_answers();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (answer_q.size() != 0);
	endtask

	// One access of any kind, with CPU addresses weighted toward the decoded windows.
	task automatic send_random_item();
		op_t         op;
		logic [15:0] addr;
		op = op_t'($urandom_range(0, 3));
		addr = 16'($urandom);
		if (op == OP_CPU_WRITE || (op == OP_CPU_READ && $urandom_range(0, 1) == 0)) begin
			case ($urandom_range(0, 5))
				0: addr = 16'h4800 + 16'($urandom_range(0, 16'h07FF));
				1: addr = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
				2: addr = 16'h8000 + 16'($urandom_range(0, 16'h3FFF));
				3: addr = 16'hC000 + 16'($urandom_range(0, 16'h1FFF));
				4: addr = 16'hE000 + 16'($urandom_range(0, 16'h1FFF));
				default: ;
			endcase
		end
		send_item(op, addr, 8'($urandom), 8'($urandom), 1'b0, '0);
	endtask

	// Loads the counter near its limit and ticks it, with other traffic mixed in.
	task automatic send_irq_burst();
		logic [7:0] hi;
		int         n_ticks;
		hi = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			hi[6:0] = 7'h7C + 7'($urandom_range(0, 3));
			hi[7] = ($urandom_range(0, 7) != 0);
		end
		send_item(OP_CPU_WRITE, 16'h8400 | (16'($urandom) & 16'h1BFF), 8'($urandom),
			8'($urandom), 1'b0, '0);
		send_item(OP_CPU_WRITE, 16'hA400 | (16'($urandom) & 16'h1BFF), hi,
			8'($urandom), 1'b0, '0);
		n_ticks = $urandom_range(3, 16);
		for (int i = 0; i < n_ticks; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				send_random_item();
			end
			send_item(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
		end
	endtask

	// Stimulus: reset, scripted accesses, random traffic, then the final check.
	initial begin : stimulus
		int loops;
		bit paused;
		loops = 0;
		paused = 1'b0;
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int row = 0; row < N_SCRIPT; row++) begin
			send_item(script[row].op, script[row].addr, script[row].wdata, script[row].cyc,
				script[row].given, script[row].answer);
		end
		drain_answers();
		while (items_issued < TOTAL_ITEMS) begin
			if (!paused && items_issued >= PAUSE_AT) begin
				paused = 1'b1;
				drain_answers();
			end
			if (items_issued >= QUIET_AT) begin
				quiet = 1'b1;
			end
			// Vary the sender's idling so that some stretches have none.
			if (loops % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: tx_idle_rate = 0;
					1: tx_idle_rate = 15;
					default: tx_idle_rate = 40;
				endcase
			end
			loops++;
			if ($urandom_range(0, 99) < 15) begin
				send_irq_burst();
			end else begin
				send_random_item();
			end
		end
		drain_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answer_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Result side readiness: random stalls and one long hold-off.
	initial begin : result_sink
		int rx_loops;
		rx_loops = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && items_issued >= HOLD_AT) begin
				rx_holding = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
				rx_holding = 1'b0;
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_rate) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
			if (rx_loops % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: rx_idle_rate = 0;
					1: rx_idle_rate = 10;
					default: rx_idle_rate = 30;
				endcase
			end
			rx_loops++;
		end
	end

	// Every result transfer is checked against the oldest booked answer.
	always @(posedge clk) begin : result_check
		bus_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata, '0);
			end else begin
				want = answer_q.pop_front();
				if (m_tuser !== want.tgt)
					report_mismatch("target", 32'(m_tuser), 32'(want.tgt));
				if (m_tdata[20:0] !== want.maddr)
					report_mismatch("mapped_address", 32'(m_tdata[20:0]), 32'(want.maddr));
				if (m_tdata[28:21] !== want.wdata)
					report_mismatch("out_data", 32'(m_tdata[28:21]), 32'(want.wdata));
				if (m_tdata[29] !== want.irq)
					report_mismatch("irq", 32'(m_tdata[29]), 32'(want.irq));
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
